FILE: sv/irrs_pkg.sv
package irrs_pkg;

   // map geometry
   localparam int MAP_BYTES  = 64;
   localparam int PTR_W      = $clog2(MAP_BYTES);
   localparam int TIME_BYTES = 8;
   localparam int TIME_W     = $clog2(TIME_BYTES);

   // fixed map locations and bits
   localparam logic [TIME_W-1:0] ADDR_SECONDS = TIME_W'(0);
   localparam logic [TIME_W-1:0] ADDR_MINUTES = TIME_W'(1);
   localparam logic [TIME_W-1:0] ADDR_HOURS   = TIME_W'(2);
   localparam logic [TIME_W-1:0] ADDR_WEEKDAY = TIME_W'(3);
   localparam logic [TIME_W-1:0] ADDR_DATE    = TIME_W'(4);
   localparam logic [TIME_W-1:0] ADDR_MONTH   = TIME_W'(5);
   localparam logic [TIME_W-1:0] ADDR_YEAR    = TIME_W'(6);
   localparam int HALT_BIT   = 7;
   localparam int MODE12_BIT = 6;
   localparam int PM_BIT     = 5;

   typedef enum logic [2:0] {
      OP_WRITE_MATCH = 3'd0,
      OP_READ_MATCH  = 3'd1,
      OP_DATA_WRITE  = 3'd2,
      OP_DATA_READ   = 3'd3,
      OP_STOP        = 3'd4
   } op_type;

   // one request word as held in the input register
   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_byte;
      logic [7:0] clock_seconds;
      logic [7:0] clock_minutes;
      logic [7:0] clock_hours;
      logic [7:0] clock_weekday;
      logic [7:0] clock_day_of_month;
      logic [7:0] clock_month;
      logic [7:0] clock_year;
   } req_word_type;

   // one response word as held in the output register
   typedef struct packed {
      logic [7:0] read_data;
      logic       set_valid;
      logic [6:0] set_seconds;
      logic [7:0] set_minutes;
      logic [7:0] set_hours;
      logic [7:0] set_weekday;
      logic [7:0] set_day_of_month;
      logic [7:0] set_month;
      logic [7:0] set_year;
   } rsp_word_type;

   // access to the ram part of the map
   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } ram_req_type;

   // two bcd digits to binary, 8-bit wrap
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
      return 8'(({4'b0, v[7:4]} * 8'd10) + {4'b0, v[3:0]});
   endfunction

   // binary to two bcd digits, divide by ten through a reciprocal
   function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
      logic [15:0] p;
      logic [4:0]  q;
      logic [7:0]  r;
      p = 16'({8'b0, v} * 16'd205);
      q = p[15:11];
      r = v - 8'({3'b0, q} * 8'd10);
      return 8'({q, 4'b0}) | {4'b0, r[3:0]};
   endfunction

   // 24-hour bcd to 12-hour form with mode and pm bits
   function automatic logic [7:0] hours_to_12(input logic [7:0] hrs);
      logic [7:0] h;
      logic       pm;
      h  = bcd_to_bin(hrs);
      pm = (h >= 8'd12);
      if (pm) begin
         h = h - 8'd12;
      end
      if (h == 8'd0) begin
         h = 8'd12;
      end
      return 8'h40 | bin_to_bcd(h) | {2'b0, pm, 5'b0};
   endfunction

   // 12-hour form back to 24-hour bcd
   function automatic logic [7:0] hours_to_24(input logic [7:0] hrs);
      logic [7:0] v;
      v = bcd_to_bin({3'b0, hrs[4:0]});
      if (v >= 8'd24) begin
         v = v - 8'd24;
      end else if (v >= 8'd12) begin
         v = v - 8'd12;
      end
      if (hrs[PM_BIT]) begin
         v = v + 8'd12;
      end
      return bin_to_bcd(v);
   endfunction

endpackage

FILE: sv/irrs_req_if.sv
interface irrs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] data_byte;
   logic [7:0] clock_seconds;
   logic [7:0] clock_minutes;
   logic [7:0] clock_hours;
   logic [7:0] clock_weekday;
   logic [7:0] clock_day_of_month;
   logic [7:0] clock_month;
   logic [7:0] clock_year;

   modport source (
      output valid, operation, data_byte, clock_seconds, clock_minutes, clock_hours,
             clock_weekday, clock_day_of_month, clock_month, clock_year,
      input  ready
   );
   modport sink (
      input  valid, operation, data_byte, clock_seconds, clock_minutes, clock_hours,
             clock_weekday, clock_day_of_month, clock_month, clock_year,
      output ready
   );
endinterface

FILE: sv/irrs_rsp_if.sv
interface irrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       set_valid;
   logic [6:0] set_seconds;
   logic [7:0] set_minutes;
   logic [7:0] set_hours;
   logic [7:0] set_weekday;
   logic [7:0] set_day_of_month;
   logic [7:0] set_month;
   logic [7:0] set_year;

   modport source (
      output valid, read_data, set_valid, set_seconds, set_minutes, set_hours,
             set_weekday, set_day_of_month, set_month, set_year,
      input  ready
   );
   modport sink (
      input  valid, read_data, set_valid, set_seconds, set_minutes, set_hours,
             set_weekday, set_day_of_month, set_month, set_year,
      output ready
   );
endinterface

FILE: sv/i2c_rtc_register_shadow_core.sv
// register side of an i2c real-time-clock slave
// req_chan carries one bus event per word: write match, read match, byte
// written, byte read or stop, with the current time for a read match.
// rsp_chan returns exactly one word for each request word: the map byte for
// a byte read, or the time to load for a stop that follows writes; all other
// fields are zero.
// a word accepted goes into the input register, and its response is registered
// in the output register when the word advances.
// throughput: one word per cycle while the receiver takes responses, set by the
// single map access per word; the ram part of the map is read as the word is
// accepted, at the address the pointer will hold when the word is processed.
// reset clears the time and control bytes, the written marks of the ram
// bytes, the pointer, the pending pointer load and the dirty mark; no
// clearing pass is needed.
// when the receiver stalls, the response stays in its register, the input
// register takes one more word and then req_chan.ready falls until the
// response is taken.
module i2c_rtc_register_shadow_core (
   input  logic       clock,
   input  logic       reset,
   irrs_req_if.sink   req_chan,
   irrs_rsp_if.source rsp_chan
);

   localparam int PTR_W  = irrs_pkg::PTR_W;
   localparam int TIME_W = irrs_pkg::TIME_W;

   logic                    s_valid_ff;
   irrs_pkg::req_word_type  s_word_ff;
   logic                    r_valid_ff;
   irrs_pkg::rsp_word_type  rsp_ff;
   irrs_pkg::rsp_word_type  rsp_in;

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic             dirty_ff, dirty_in;
   logic [7:0]       tm_ff [irrs_pkg::TIME_BYTES];
   logic [7:0]       tm_in [irrs_pkg::TIME_BYTES];

   irrs_pkg::ram_req_type ram_req;
   logic [7:0]            ram_rd_data;
   logic                  accept;
   logic                  adv;
   logic [PTR_W-1:0]      ptr_next;
   logic                  ptr_in_time;

   // handshake
   assign adv           = s_valid_ff && (!r_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s_valid_ff || adv;
   assign accept        = req_chan.valid && req_chan.ready;
   assign ptr_in_time   = (ptr_ff < PTR_W'(irrs_pkg::TIME_BYTES));
   assign ptr_next      = (ptr_ff == PTR_W'(irrs_pkg::MAP_BYTES - 1)) ? '0 : ptr_ff + 1'b1;

   irrs_map_ram u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (accept) begin
         s_valid_ff <= 1'b1;
      end else if (adv) begin
         s_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s_word_ff.operation          <= req_chan.operation;
         s_word_ff.data_byte          <= req_chan.data_byte;
         s_word_ff.clock_seconds      <= req_chan.clock_seconds;
         s_word_ff.clock_minutes      <= req_chan.clock_minutes;
         s_word_ff.clock_hours        <= req_chan.clock_hours;
         s_word_ff.clock_weekday      <= req_chan.clock_weekday;
         s_word_ff.clock_day_of_month <= req_chan.clock_day_of_month;
         s_word_ff.clock_month        <= req_chan.clock_month;
         s_word_ff.clock_year         <= req_chan.clock_year;
      end
   end

   // event decode, map update and response build
   always_comb begin
      ptr_in   = ptr_ff;
      pend_in  = pend_ff;
      dirty_in = dirty_ff;
      tm_in    = tm_ff;
      rsp_in   = '0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = ptr_ff;
      ram_req.wr_data = s_word_ff.data_byte;
      if (adv) begin
         unique case (s_word_ff.operation)
            irrs_pkg::OP_WRITE_MATCH: begin
               pend_in = 1'b1;
            end
            irrs_pkg::OP_READ_MATCH: begin
               tm_in[irrs_pkg::ADDR_SECONDS] = s_word_ff.clock_seconds
                  | {tm_ff[irrs_pkg::ADDR_SECONDS][irrs_pkg::HALT_BIT], 7'b0};
               tm_in[irrs_pkg::ADDR_MINUTES] = s_word_ff.clock_minutes;
               if (tm_ff[irrs_pkg::ADDR_HOURS][irrs_pkg::MODE12_BIT]) begin
                  tm_in[irrs_pkg::ADDR_HOURS] = irrs_pkg::hours_to_12(s_word_ff.clock_hours);
               end else begin
                  tm_in[irrs_pkg::ADDR_HOURS] = s_word_ff.clock_hours;
               end
               tm_in[irrs_pkg::ADDR_WEEKDAY] = s_word_ff.clock_weekday;
               tm_in[irrs_pkg::ADDR_DATE]    = s_word_ff.clock_day_of_month;
               tm_in[irrs_pkg::ADDR_MONTH]   = s_word_ff.clock_month;
               tm_in[irrs_pkg::ADDR_YEAR]    = s_word_ff.clock_year;
            end
            irrs_pkg::OP_DATA_WRITE: begin
               if (pend_ff) begin
                  ptr_in  = PTR_W'(s_word_ff.data_byte % irrs_pkg::MAP_BYTES);
                  pend_in = 1'b0;
               end else begin
                  if (ptr_in_time) begin
                     tm_in[ptr_ff[TIME_W-1:0]] = s_word_ff.data_byte;
                  end else begin
                     ram_req.wr_en = 1'b1;
                  end
                  ptr_in   = ptr_next;
                  dirty_in = 1'b1;
               end
            end
            irrs_pkg::OP_DATA_READ: begin
               rsp_in.read_data = ptr_in_time ? tm_ff[ptr_ff[TIME_W-1:0]] : ram_rd_data;
               ptr_in           = ptr_next;
            end
            irrs_pkg::OP_STOP: begin
               if (dirty_ff) begin
                  rsp_in.set_valid   = 1'b1;
                  rsp_in.set_seconds = tm_ff[irrs_pkg::ADDR_SECONDS][6:0];
                  rsp_in.set_minutes = tm_ff[irrs_pkg::ADDR_MINUTES];
                  if (tm_ff[irrs_pkg::ADDR_HOURS][irrs_pkg::MODE12_BIT]) begin
                     rsp_in.set_hours = irrs_pkg::hours_to_24(tm_ff[irrs_pkg::ADDR_HOURS]);
                  end else begin
                     rsp_in.set_hours = tm_ff[irrs_pkg::ADDR_HOURS];
                  end
                  rsp_in.set_weekday      = tm_ff[irrs_pkg::ADDR_WEEKDAY];
                  rsp_in.set_day_of_month = tm_ff[irrs_pkg::ADDR_DATE];
                  rsp_in.set_month        = tm_ff[irrs_pkg::ADDR_MONTH];
                  rsp_in.set_year         = tm_ff[irrs_pkg::ADDR_YEAR];
                  dirty_in                = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      // ram read for the word being taken, at the pointer it will see
      ram_req.rd_en   = accept;
      ram_req.rd_addr = ptr_in;
   end

   // pointer, flags and time bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
         dirty_ff <= 1'b0;
         for (int i = 0; i < irrs_pkg::TIME_BYTES; i++) begin
            tm_ff[i] <= 8'h00;
         end
      end else begin
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
         dirty_ff <= dirty_in;
         tm_ff    <= tm_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (adv) begin
         r_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         r_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid            = r_valid_ff;
   assign rsp_chan.read_data        = rsp_ff.read_data;
   assign rsp_chan.set_valid        = rsp_ff.set_valid;
   assign rsp_chan.set_seconds      = rsp_ff.set_seconds;
   assign rsp_chan.set_minutes      = rsp_ff.set_minutes;
   assign rsp_chan.set_hours        = rsp_ff.set_hours;
   assign rsp_chan.set_weekday      = rsp_ff.set_weekday;
   assign rsp_chan.set_day_of_month = rsp_ff.set_day_of_month;
   assign rsp_chan.set_month        = rsp_ff.set_month;
   assign rsp_chan.set_year         = rsp_ff.set_year;

   // checks
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff < PTR_W'(irrs_pkg::MAP_BYTES - 1) || ptr_ff == PTR_W'(irrs_pkg::MAP_BYTES - 1))
      else $error("byte pointer out of map");

   a_stop_clears_dirty: assert property (@(posedge clock) disable iff (reset)
      adv && s_word_ff.operation == irrs_pkg::OP_STOP |=> !dirty_ff)
      else $error("dirty mark survived a stop");

   a_set_excl_read: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff && rsp_ff.set_valid |-> rsp_ff.read_data == 8'h00)
      else $error("load word carries read data");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff && !rsp_chan.ready |=> r_valid_ff && $stable(rsp_ff))
      else $error("stalled response lost");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s_valid_ff |-> req_chan.ready)
      else $error("empty input register refuses a word");

endmodule

FILE: sv/irrs_map_ram.sv
module irrs_map_ram (
   input  logic                      clock,
   input  logic                      reset,
   input  irrs_pkg::ram_req_type     ram_req,
   output logic [7:0]                rd_data
);

   logic [7:0]                     mem [irrs_pkg::MAP_BYTES];
   logic [irrs_pkg::MAP_BYTES-1:0] valid_ff;
   logic [7:0]                     rd_data_ff;
   logic                           rd_valid_ff;

   // ram array, one write and one registered read
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   // written marks, cleared at reset so that unwritten bytes read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) begin
            valid_ff[ram_req.wr_addr] <= 1'b1;
         end
         if (ram_req.rd_en) begin
            rd_valid_ff <= valid_ff[ram_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'h00;

endmodule

FILE: tb/testbench.sv
module testbench;

   localparam int PTR_W = irrs_pkg::PTR_W;

   // operation codes the block treats as no-ops
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   localparam int RANDOM_WORDS  = 620;
   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 80;

   localparam irrs_pkg::rsp_word_type NO_RESULT = '0;

   typedef struct {
      irrs_pkg::req_word_type word;
      bit                     typed;
      irrs_pkg::rsp_word_type answer;
   } script_row_type;

   logic clock;
   logic reset;

   irrs_req_if req_chan ();
   irrs_rsp_if rsp_chan ();

   i2c_rtc_register_shadow_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the block state
   logic [7:0]       shadow_map [irrs_pkg::MAP_BYTES];
   logic [PTR_W-1:0] shadow_ptr;
   bit               load_armed;
   bit               map_written;

   irrs_pkg::rsp_word_type pending_responses [$];
   script_row_type         script [$];
   int                     mismatch_count = 0;
   int                     words_sent     = 0;
   bit                     steady         = 1'b0;
   bit                     hold_request   = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] bcd_value(input logic [7:0] v);
      return 8'(v[7:4] * 10 + v[3:0]);
   endfunction

   function automatic logic [7:0] bcd_digits(input logic [7:0] v);
      int unsigned tens;
      int unsigned ones;
      tens = v / 10;
      ones = v % 10;
      return 8'((tens << 4) | ones);
   endfunction

   // next response word and shadow state update for one bus event
   function automatic irrs_pkg::rsp_word_type shadow_response(input irrs_pkg::req_word_type w);
      irrs_pkg::rsp_word_type r;
      logic [7:0]             h;
      logic [7:0]             hrs;
      logic                   pm;
      r = '0;
      unique case (w.operation)
         irrs_pkg::OP_WRITE_MATCH: begin
            load_armed = 1'b1;
         end
         irrs_pkg::OP_READ_MATCH: begin
            shadow_map[irrs_pkg::ADDR_SECONDS] = w.clock_seconds |
               {shadow_map[irrs_pkg::ADDR_SECONDS][irrs_pkg::HALT_BIT], 7'b0};
            shadow_map[irrs_pkg::ADDR_MINUTES] = w.clock_minutes;
            if (shadow_map[irrs_pkg::ADDR_HOURS][irrs_pkg::MODE12_BIT]) begin
               h  = bcd_value(w.clock_hours);
               pm = (h >= 8'd12);
               if (pm) begin
                  h = h - 8'd12;
               end
               if (h == 8'd0) begin
                  h = 8'd12;
               end
               shadow_map[irrs_pkg::ADDR_HOURS] = 8'(1 << irrs_pkg::MODE12_BIT) |
                                                  bcd_digits(h) | {2'b0, pm, 5'b0};
            end else begin
               shadow_map[irrs_pkg::ADDR_HOURS] = w.clock_hours;
            end
            shadow_map[irrs_pkg::ADDR_WEEKDAY] = w.clock_weekday;
            shadow_map[irrs_pkg::ADDR_DATE]    = w.clock_day_of_month;
            shadow_map[irrs_pkg::ADDR_MONTH]   = w.clock_month;
            shadow_map[irrs_pkg::ADDR_YEAR]    = w.clock_year;
         end
         irrs_pkg::OP_DATA_WRITE: begin
            if (load_armed) begin
               shadow_ptr = PTR_W'(w.data_byte % irrs_pkg::MAP_BYTES);
               load_armed = 1'b0;
            end else begin
               shadow_map[shadow_ptr] = w.data_byte;
               shadow_ptr  = PTR_W'((shadow_ptr + 1) % irrs_pkg::MAP_BYTES);
               map_written = 1'b1;
            end
         end
         irrs_pkg::OP_DATA_READ: begin
            r.read_data = shadow_map[shadow_ptr];
            shadow_ptr  = PTR_W'((shadow_ptr + 1) % irrs_pkg::MAP_BYTES);
         end
         irrs_pkg::OP_STOP: begin
            if (map_written) begin
               hrs = shadow_map[irrs_pkg::ADDR_HOURS];
               // 12-hour form goes back to 24-hour bcd
               if (hrs[irrs_pkg::MODE12_BIT]) begin
                  h   = 8'(bcd_value({3'b0, hrs[4:0]}) % 12 +
                           (hrs[irrs_pkg::PM_BIT] ? 12 : 0));
                  hrs = bcd_digits(h);
               end
               r.set_valid        = 1'b1;
               r.set_seconds      = shadow_map[irrs_pkg::ADDR_SECONDS][6:0];
               r.set_minutes      = shadow_map[irrs_pkg::ADDR_MINUTES];
               r.set_hours        = hrs;
               r.set_weekday      = shadow_map[irrs_pkg::ADDR_WEEKDAY];
               r.set_day_of_month = shadow_map[irrs_pkg::ADDR_DATE];
               r.set_month        = shadow_map[irrs_pkg::ADDR_MONTH];
               r.set_year         = shadow_map[irrs_pkg::ADDR_YEAR];
               map_written = 1'b0;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         report_mismatch(name, got, want);
      end
   endtask

   function automatic irrs_pkg::req_word_type bus_word(input logic [2:0] op,
                                                       input logic [7:0] data);
      irrs_pkg::req_word_type w;
      w = '0;
      w.operation = op;
      w.data_byte = data;
      return w;
   endfunction

   function automatic irrs_pkg::req_word_type time_word(input logic [7:0] sec,
                                                        input logic [7:0] min,
                                                        input logic [7:0] hrs,
                                                        input logic [7:0] wday,
                                                        input logic [7:0] date,
                                                        input logic [7:0] mon,
                                                        input logic [7:0] yr);
      irrs_pkg::req_word_type w;
      w = '0;
      w.operation          = irrs_pkg::OP_READ_MATCH;
      w.clock_seconds      = sec;
      w.clock_minutes      = min;
      w.clock_hours        = hrs;
      w.clock_weekday      = wday;
      w.clock_day_of_month = date;
      w.clock_month        = mon;
      w.clock_year         = yr;
      return w;
   endfunction

   function automatic irrs_pkg::req_word_type noise_word();
      irrs_pkg::req_word_type w;
      w.operation          = 3'($urandom_range(0, 7));
      w.data_byte          = 8'($urandom);
      w.clock_seconds      = 8'($urandom);
      w.clock_minutes      = 8'($urandom);
      w.clock_hours        = 8'($urandom);
      w.clock_weekday      = 8'($urandom);
      w.clock_day_of_month = 8'($urandom);
      w.clock_month        = 8'($urandom);
      w.clock_year         = 8'($urandom);
      return w;
   endfunction

   task automatic add_row(input irrs_pkg::req_word_type w, input bit typed,
                          input irrs_pkg::rsp_word_type answer);
      script_row_type row;
      row.word   = w;
      row.typed  = typed;
      row.answer = answer;
      script.push_back(row);
   endtask

   // offer one word, with random idle cycles ahead of it
   task automatic send(input irrs_pkg::req_word_type w, input bit typed,
                       input irrs_pkg::rsp_word_type answer);
      irrs_pkg::rsp_word_type predicted;
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.operation          <= w.operation;
      req_chan.data_byte          <= w.data_byte;
      req_chan.clock_seconds      <= w.clock_seconds;
      req_chan.clock_minutes      <= w.clock_minutes;
      req_chan.clock_hours        <= w.clock_hours;
      req_chan.clock_weekday      <= w.clock_weekday;
      req_chan.clock_day_of_month <= w.clock_day_of_month;
      req_chan.clock_month        <= w.clock_month;
      req_chan.clock_year         <= w.clock_year;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      predicted = shadow_response(w);
      pending_responses.push_back(typed ? answer : predicted);
      words_sent++;
   endtask

   task automatic wait_for_responses();
      req_chan.valid <= 1'b0;
      while (pending_responses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // master writes: pointer byte, a few data bytes, usually a stop
   task automatic write_transfer();
      irrs_pkg::req_word_type w;
      int                     n;
      n = $urandom_range(1, 6);
      w = noise_word();
      w.operation = irrs_pkg::OP_WRITE_MATCH;
      send(w, 1'b0, NO_RESULT);
      w = noise_word();
      w.operation = irrs_pkg::OP_DATA_WRITE;
      if ($urandom_range(0, 9) < 7) begin
         w.data_byte = 8'($urandom_range(0, 9));
      end
      send(w, 1'b0, NO_RESULT);
      repeat (n) begin
         w = noise_word();
         w.operation = irrs_pkg::OP_DATA_WRITE;
         send(w, 1'b0, NO_RESULT);
      end
      if ($urandom_range(0, 9) < 9) begin
         send(bus_word(irrs_pkg::OP_STOP, 8'($urandom)), 1'b0, NO_RESULT);
      end
   endtask

   // master reads: optional pointer set, read match with the time, reads, usually a stop
   task automatic read_transfer();
      irrs_pkg::req_word_type w;
      int                     n;
      n = $urandom_range(1, 8);
      if ($urandom_range(0, 1) == 1) begin
         send(bus_word(irrs_pkg::OP_WRITE_MATCH, 8'($urandom)), 1'b0, NO_RESULT);
         send(bus_word(irrs_pkg::OP_DATA_WRITE, 8'($urandom_range(0, 7))), 1'b0, NO_RESULT);
      end
      w = noise_word();
      w.operation = irrs_pkg::OP_READ_MATCH;
      // mostly a sane time, otherwise raw bytes
      if ($urandom_range(0, 9) < 7) begin
         w.clock_seconds      = bcd_digits(8'($urandom_range(0, 59)));
         w.clock_minutes      = bcd_digits(8'($urandom_range(0, 59)));
         w.clock_hours        = bcd_digits(8'($urandom_range(0, 23)));
         w.clock_weekday      = 8'($urandom_range(1, 7));
         w.clock_day_of_month = bcd_digits(8'($urandom_range(1, 31)));
         w.clock_month        = bcd_digits(8'($urandom_range(1, 12)));
         w.clock_year         = bcd_digits(8'($urandom_range(0, 99)));
      end
      send(w, 1'b0, NO_RESULT);
      repeat (n) begin
         send(bus_word(irrs_pkg::OP_DATA_READ, 8'($urandom)), 1'b0, NO_RESULT);
      end
      if ($urandom_range(0, 9) < 9) begin
         send(bus_word(irrs_pkg::OP_STOP, 8'($urandom)), 1'b0, NO_RESULT);
      end
   endtask

   // stimulus and end of run
   initial begin
      int  directed_count;
      int  random_done;
      int  pick;
      bit  hold_done;
      bit  pause_done;
      reset                       <= 1'b1;
      req_chan.valid              <= 1'b0;
      req_chan.operation          <= '0;
      req_chan.data_byte          <= '0;
      req_chan.clock_seconds      <= '0;
      req_chan.clock_minutes      <= '0;
      req_chan.clock_hours        <= '0;
      req_chan.clock_weekday      <= '0;
      req_chan.clock_day_of_month <= '0;
      req_chan.clock_month        <= '0;
      req_chan.clock_year         <= '0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      foreach (shadow_map[i]) begin
         shadow_map[i] = 8'h00;
      end
      shadow_ptr  = '0;
      load_armed  = 1'b0;
      map_written = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      add_row(bus_word(irrs_pkg::OP_DATA_READ, 8'h00), 1'b1, NO_RESULT); // map clear after reset
      add_row(bus_word(irrs_pkg::OP_STOP, 8'h00), 1'b1, NO_RESULT);      // stop with clean map
      add_row(bus_word(OP_SPARE_LO, 8'hFF), 1'b1, NO_RESULT);
      add_row(bus_word(OP_SPARE_MID, 8'h00), 1'b1, NO_RESULT);
      add_row(bus_word(OP_SPARE_HI, 8'hFF), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_WRITE_MATCH, 8'h00), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_DATA_WRITE, 8'h02), 1'b1, NO_RESULT); // pointer to hours
      add_row(bus_word(irrs_pkg::OP_DATA_WRITE, 8'h40), 1'b1, NO_RESULT); // 12-hour mode
      add_row(bus_word(irrs_pkg::OP_STOP, 8'h00), 1'b0, NO_RESULT);
      add_row(time_word(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_WRITE_MATCH, 8'h00), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_DATA_WRITE, 8'h00), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_DATA_READ, 8'h00), 1'b0, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_DATA_READ, 8'h00), 1'b0, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_DATA_READ, 8'h00), 1'b0, NO_RESULT); // midnight as 12 am
      add_row(time_word(8'h59, 8'h30, 8'h23, 8'h01, 8'h31, 8'h12, 8'h99), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_WRITE_MATCH, 8'h00), 1'b1, NO_RESULT);
      // pointer taken mod map size
      add_row(bus_word(irrs_pkg::OP_DATA_WRITE, 8'hFF), 1'b1, NO_RESULT);
      // last byte, pointer wraps
      add_row(bus_word(irrs_pkg::OP_DATA_WRITE, 8'hA5), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_STOP, 8'h00), 1'b0, NO_RESULT); // halt bit dropped, pm back
      add_row(bus_word(irrs_pkg::OP_DATA_READ, 8'h00), 1'b0, NO_RESULT);
      add_row(time_word(8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_WRITE_MATCH, 8'h00), 1'b1, NO_RESULT);
      // clean stop keeps load armed
      add_row(bus_word(irrs_pkg::OP_STOP, 8'h00), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_DATA_WRITE, 8'h7F), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_DATA_READ, 8'h00), 1'b0, NO_RESULT);
      // seconds with halt bit and bad bcd
      add_row(bus_word(irrs_pkg::OP_DATA_WRITE, 8'h99), 1'b1, NO_RESULT);
      add_row(bus_word(irrs_pkg::OP_STOP, 8'h00), 1'b0, NO_RESULT);
      foreach (script[i]) begin
         send(script[i].word, script[i].typed, script[i].answer);
      end
      wait_for_responses();
      directed_count = words_sent;

      // random transfers
      random_done = 0;
      while (random_done < RANDOM_WORDS) begin
         steady = (random_done >= 200 && random_done < 320);
         if (!hold_done && random_done >= 420) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if (!pause_done && random_done >= 520) begin
            wait_for_responses();
            pause_done = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            write_transfer();
         end else if (pick < 8) begin
            read_transfer();
         end else begin
            repeat ($urandom_range(1, 3)) send(noise_word(), 1'b0, NO_RESULT);
         end
         random_done = words_sent - directed_count;
      end
      steady = 1'b0;

      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // response side: check accepted words, drive ready
   initial begin
      irrs_pkg::rsp_word_type want;
      int                     hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("word with nothing expected, read_data",
                               rsp_chan.read_data, 8'h00);
            end else begin
               want = pending_responses.pop_front();
               compare_field("read_data", rsp_chan.read_data, want.read_data);
               compare_field("set_valid", {7'b0, rsp_chan.set_valid}, {7'b0, want.set_valid});
               compare_field("set_seconds", {1'b0, rsp_chan.set_seconds},
                             {1'b0, want.set_seconds});
               compare_field("set_minutes", rsp_chan.set_minutes, want.set_minutes);
               compare_field("set_hours", rsp_chan.set_hours, want.set_hours);
               compare_field("set_weekday", rsp_chan.set_weekday, want.set_weekday);
               compare_field("set_day_of_month", rsp_chan.set_day_of_month,
                             want.set_day_of_month);
               compare_field("set_month", rsp_chan.set_month, want.set_month);
               compare_field("set_year", rsp_chan.set_year, want.set_year);
            end
         end
         // long hold-off so the block backs up into its input
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 28);
         end
      end
   end

   // watchdog on cycles with no word moving either way
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
sv/irrs_pkg.sv
sv/irrs_req_if.sv
sv/irrs_rsp_if.sv
sv/irrs_map_ram.sv
sv/i2c_rtc_register_shadow_core.sv
tb/testbench.sv
